// File: rtl/jof_pkg.sv
package jof_pkg;

    localparam int DEPTH_BITS = 16;

    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       ovf;
    } res_t;

endpackage

// File: rtl/jof_scan.sv
module jof_scan
    import jof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] scan_byte,
    input  logic       step,
    output logic       emit,
    output res_t       res
);

    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic                  obj_reg;
    logic                  obj_next;
    logic                  quote_reg;
    logic                  quote_next;
    logic                  esc_reg;
    logic                  esc_next;
    logic                  first;
    logic                  last;
    logic                  ovf;

    always_comb
    begin
        depth_next = depth_reg;
        obj_next   = obj_reg;
        quote_next = quote_reg;
        esc_next   = 1'b0;
        emit       = obj_reg;
        first      = 1'b0;
        last       = 1'b0;
        ovf        = 1'b0;
        if (esc_reg)
        begin
            esc_next = 1'b0;
        end
        else if (quote_reg)
        begin
            if (scan_byte == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (scan_byte == CH_QUOTE)
            begin
                quote_next = 1'b0;
            end
        end
        else if (scan_byte == CH_QUOTE)
        begin
            quote_next = 1'b1;
        end
        else if (!obj_reg)
        begin
            if (scan_byte == CH_OPEN)
            begin
                obj_next   = 1'b1;
                depth_next = DEPTH_ONE;
                emit       = 1'b1;
                first      = 1'b1;
            end
        end
        else if (scan_byte == CH_OPEN)
        begin
            if (depth_reg == DEPTH_MAX)
            begin
                ovf = 1'b1;
            end
            else
            begin
                depth_next = depth_reg + DEPTH_ONE;
            end
        end
        else if (scan_byte == CH_CLOSE)
        begin
            if (depth_reg <= DEPTH_ONE)
            begin
                last = 1'b1;
            end
            else
            begin
                depth_next = depth_reg - DEPTH_ONE;
            end
        end
        // message done, everything back to idle
        if (last)
        begin
            depth_next = '0;
            obj_next   = 1'b0;
            quote_next = 1'b0;
            esc_next   = 1'b0;
        end
    end

    assign res.data  = scan_byte;
    assign res.first = first;
    assign res.last  = last;
    assign res.ovf   = ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            obj_reg   <= 1'b0;
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
        end
        else if (step)
        begin
            depth_reg <= depth_next;
            obj_reg   <= obj_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

// File: rtl/jof_out.sv
module jof_out
    import jof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       msg_first,
    output logic       msg_last,
    output logic       depth_overflow
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = res_reg.data;
    assign msg_first      = res_reg.first;
    assign msg_last       = res_reg.last;
    assign depth_overflow = res_reg.ovf;

endmodule

// File: rtl/json_object_framer_core.sv
// pipeline: 2 register stages, input then result; an accepted input item is held in the
// input register, then its result in the result register, and an output stall can hold either
// throughput: one byte per cycle unless the output stalls; the input register is scanned combinationally
// bytes outside a message give no result
// reset (rst_n low, asynchronous) clears depth, message, quoting and escape state and
// both pipeline valid flags; payload registers are not reset
module json_object_framer_core
    import jof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       msg_first,
    output logic       msg_last,
    output logic       depth_overflow
);

    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       emit;
    logic       out_ready;
    logic       advance;
    res_t       res;

    assign advance  = in_v_reg && (!emit || out_ready);
    assign in_stall = in_v_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    jof_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_byte (in_byte_reg),
        .step      (advance),
        .emit      (emit),
        .res       (res)
    );

    jof_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (advance && emit),
        .res            (res),
        .ready          (out_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .msg_first      (msg_first),
        .msg_last       (msg_last),
        .depth_overflow (depth_overflow)
    );

endmodule

// File: rtl/jof_checker.sv
module jof_checker
    import jof_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       msg_first,
    input logic       msg_last,
    input logic       depth_overflow
);

    logic in_msg_reg;
    logic out_take;

    assign out_take = out_valid && !out_stall;

    // tracks whether delivered items are inside a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else if (out_take)
        begin
            in_msg_reg <= !msg_last;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(msg_first)
            && $stable(msg_last) && $stable(depth_overflow))
        else $error("stalled output item changed");

    a_framing: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (msg_first == !in_msg_reg))
        else $error("message start does not follow message end");

    a_first_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && msg_first |-> out_byte == CH_OPEN && !msg_last && !depth_overflow)
        else $error("bad first item of a message");

    a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && msg_last |-> out_byte == CH_CLOSE)
        else $error("last item is not a closing brace");

endmodule

bind json_object_framer_core jof_checker u_jof_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .msg_first      (msg_first),
    .msg_last       (msg_last),
    .depth_overflow (depth_overflow)
);
